@@ design/refor_pkg.sv @@
// Constants, stage map and saturating fixed-point helpers of the ellipse fluid-dynamics block.
`default_nettype none

package refor_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int TRIG_FRAC     = 30;
    localparam int CORDIC_STEPS  = 18;
    localparam int CORDIC_BITS   = 34;
    localparam int DIV_STEPS     = WORD_BITS + FRAC_BITS;
    localparam int TURN_SHIFT    = FRAC_BITS + 32;
    localparam int NUM_MULS      = 6;
    localparam int NUM_DIVS      = 3;
    localparam int NUM_SLOTS     = 8;
    localparam int MASS_BITS     = 31;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [63:0] INV_TURN = 64'h28BE60DB9391054A;
    localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [CFG_ADDR_BITS-1:0] REG_MASS_ONE = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MASS_TWO = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INERTIA  = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FORCE    = 2'd3;

    localparam int ST_IN      = 0;
    localparam int ST_TURN    = 1;
    localparam int ST_CORD0   = 2;
    localparam int ST_TRIG    = ST_CORD0 + CORDIC_STEPS;
    localparam int ST_P1      = ST_TRIG + 1;
    localparam int ST_R1      = ST_P1 + 1;
    localparam int ST_B       = ST_R1 + 1;
    localparam int ST_P2      = ST_B + 1;
    localparam int ST_R2      = ST_P2 + 1;
    localparam int ST_P3      = ST_R2 + 1;
    localparam int ST_R3      = ST_P3 + 1;
    localparam int ST_NUM     = ST_R3 + 1;
    localparam int ST_DSET    = ST_NUM + 1;
    localparam int ST_DIV0    = ST_DSET + 1;
    localparam int ST_DFIN    = ST_DIV0 + DIV_STEPS;
    localparam int ST_P4      = ST_DFIN + 1;
    localparam int ST_R4      = ST_P4 + 1;
    localparam int ST_S1      = ST_R4 + 1;
    localparam int ST_OUT     = ST_S1 + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_BITS-1:0] mag_word(input t_word a);
        logic [WORD_BITS-1:0] v;
        v = a[WORD_BITS-1] ? (0 - a) : a;
        return v;
    endfunction

    // Returns the clip flag above the signed word.
    function automatic logic [WORD_BITS:0] sat_mag(input logic neg, input logic [63:0] q);
        logic [63:0] lim;
        logic [WORD_BITS-1:0] low;
        lim = neg ? (64'd1 << (WORD_BITS-1)) : ((64'd1 << (WORD_BITS-1)) - 64'd1);
        low = q[WORD_BITS-1:0];
        if (q > lim) begin
            return {1'b1, neg ? WORD_MIN : WORD_MAX};
        end
        return {1'b0, neg ? (0 - low) : low};
    endfunction

    function automatic logic [WORD_BITS:0] mul_round(input logic neg, input logic [63:0] prod,
                                                      input int unsigned shift);
        logic [63:0] sum;
        sum = prod + (64'd1 << (shift - 1));
        return sat_mag(neg, sum >> shift);
    endfunction

    function automatic logic [WORD_BITS:0] sat_add(input t_word a, input t_word b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return {1'b1, s[WORD_BITS] ? WORD_MIN : WORD_MAX};
        end
        return {1'b0, s[WORD_BITS-1:0]};
    endfunction

    function automatic logic [WORD_BITS:0] sat_neg(input t_word a);
        if (a == WORD_MIN) begin
            return {1'b1, WORD_MAX};
        end
        return {1'b0, 0 - a};
    endfunction

    function automatic logic [WORD_BITS:0] sat_sub(input t_word a, input t_word b);
        logic [WORD_BITS:0] n;
        logic [WORD_BITS:0] r;
        n = sat_neg(b);
        r = sat_add(a, n[WORD_BITS-1:0]);
        return {n[WORD_BITS] | r[WORD_BITS], r[WORD_BITS-1:0]};
    endfunction

endpackage

`default_nettype wire

@@ design/rigid_ellipse_fluid_ode_rhs.sv @@
// Pipelined right-hand side of the planar rigid-ellipse equations in an ideal fluid.
//
// Input beats on the s_axis channel carry angle, vel_x, vel_y and spin; each
// accepted beat produces exactly one output beat on the m_axis channel carrying
// the position rates, the three saturated accelerations and the clip flag.
// The masses, inertia and vertical force are set through the write port and must
// only change while no beat is in flight.
// The datapath is a pipeline of 83 register stages: the angle reduction, one
// stage per CORDIC step, registered multiplier and rounding stages, and a
// restoring divider that resolves one quotient bit per stage over 48 stages.
// A new beat can be accepted in every cycle in which the receiver does not
// hold the pipeline.
// When the receiver holds tready low with a result waiting, the whole pipeline
// freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset clears every valid bit and returns the registers to unit masses and
// zero force.
`default_nettype none

module rigid_ellipse_fluid_ode_rhs import refor_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  wire logic [WORD_BITS-1:0]       i_cfg_wdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // angle, vel_x, vel_y, spin
    input  wire logic [4*WORD_BITS-1:0]     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // rate_x, rate_y, rate_angle, accel_x, accel_y, accel_spin
    output logic [6*WORD_BITS-1:0]          m_axis_tdata,
    // saturated
    output logic [0:0]                      m_axis_tuser
);

    typedef struct {
        t_word                          vx;
        t_word                          vy;
        t_word                          om;
        logic                           clip;
        logic                           ang_neg;
        logic [63:0]                    pa_lo;
        logic [63:0]                    pa_hi;
        logic                           flip;
        logic signed [CORDIC_BITS-1:0]  cx;
        logic signed [CORDIC_BITS-1:0]  cy;
        logic signed [CORDIC_BITS-1:0]  cz;
        t_word                          c;
        t_word                          s;
        logic [63:0]                    mp   [NUM_MULS];
        logic                           mn   [NUM_MULS];
        t_word                          w    [NUM_SLOTS];
        logic [DIV_STEPS-1:0]           dn   [NUM_DIVS];
        logic [WORD_BITS-1:0]           rem  [NUM_DIVS];
        logic [DIV_STEPS-1:0]           q    [NUM_DIVS];
        logic                           dneg [NUM_DIVS];
        logic                           dnz  [NUM_DIVS];
    } t_stage;

    logic [MASS_BITS-1:0]   r_mass_one;
    logic [MASS_BITS-1:0]   r_mass_two;
    logic [MASS_BITS-1:0]   r_inertia;
    t_word                  r_force;

    t_stage                 r_pipe [NUM_STAGES];
    t_stage                 n_pipe [NUM_STAGES];
    logic [NUM_STAGES-1:0]  r_vld;
    logic [NUM_STAGES-1:0]  n_vld;
    logic                   w_adv;
    logic [WORD_BITS-1:0]   w_den [NUM_DIVS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_one <= MASS_BITS'(65536);
            r_mass_two <= MASS_BITS'(65536);
            r_inertia  <= MASS_BITS'(65536);
            r_force    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MASS_ONE: r_mass_one <= i_cfg_wdata[MASS_BITS-1:0];
                REG_MASS_TWO: r_mass_two <= i_cfg_wdata[MASS_BITS-1:0];
                REG_INERTIA:  r_inertia  <= i_cfg_wdata[MASS_BITS-1:0];
                REG_FORCE:    r_force    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_den[0] = {1'b0, r_mass_one};
    assign w_den[1] = {1'b0, r_mass_two};
    assign w_den[2] = {1'b0, r_inertia};

    assign w_adv         = !r_vld[ST_OUT] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign n_vld         = {r_vld[NUM_STAGES-2:0], s_axis_tvalid};

    always_comb begin
        t_word                          v_ang;
        t_word                          v_m1;
        t_word                          v_m2;
        t_word                          v_num;
        logic [WORD_BITS-1:0]           v_ma;
        logic [79:0]                    v_sum;
        logic [31:0]                    v_phase;
        logic signed [CORDIC_BITS-1:0]  v_dx;
        logic signed [CORDIC_BITS-1:0]  v_dy;
        logic signed [CORDIC_BITS-1:0]  v_at;
        logic signed [CORDIC_BITS-1:0]  v_cx;
        logic signed [CORDIC_BITS-1:0]  v_cy;
        logic [WORD_BITS:0]             v_res;
        logic [WORD_BITS:0]             v_dm;
        logic [WORD_BITS-1:0]           v_rem2;
        logic                           v_ge;
        logic [DIV_STEPS:0]             v_q;

        // Input stage and the two halves of the turn product.
        n_pipe[ST_IN]         = r_pipe[ST_IN];
        v_ang                 = s_axis_tdata[WORD_BITS-1:0];
        n_pipe[ST_IN].vx      = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
        n_pipe[ST_IN].vy      = s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS];
        n_pipe[ST_IN].om      = s_axis_tdata[4*WORD_BITS-1:3*WORD_BITS];
        n_pipe[ST_IN].clip    = 1'b0;
        n_pipe[ST_IN].ang_neg = v_ang[WORD_BITS-1];
        v_ma                  = mag_word(v_ang);
        n_pipe[ST_IN].pa_lo   = v_ma * INV_TURN[31:0];
        n_pipe[ST_IN].pa_hi   = v_ma * INV_TURN[63:32];

        // Binary angle, half-turn fold and CORDIC start.
        n_pipe[ST_TURN] = r_pipe[ST_TURN-1];
        v_sum = {r_pipe[ST_TURN-1].pa_hi[47:0], 32'b0} + {16'b0, r_pipe[ST_TURN-1].pa_lo}
              + (80'd1 << (TURN_SHIFT - 1));
        v_phase = v_sum[TURN_SHIFT +: 32];
        if (r_pipe[ST_TURN-1].ang_neg) begin
            v_phase = 32'd0 - v_phase;
        end
        n_pipe[ST_TURN].flip = v_phase[31] ^ v_phase[30];
        if (v_phase[31] ^ v_phase[30]) begin
            v_phase[31] = ~v_phase[31];
        end
        n_pipe[ST_TURN].cz = CORDIC_BITS'($signed(v_phase));
        n_pipe[ST_TURN].cx = CORDIC_GAIN;
        n_pipe[ST_TURN].cy = '0;

        for (int i = 0; i < CORDIC_STEPS; i++) begin
            n_pipe[ST_CORD0+i] = r_pipe[ST_CORD0+i-1];
            v_dx = r_pipe[ST_CORD0+i-1].cy >>> i;
            v_dy = r_pipe[ST_CORD0+i-1].cx >>> i;
            v_at = $signed({2'b00, atan_turn(i)});
            if (!r_pipe[ST_CORD0+i-1].cz[CORDIC_BITS-1]) begin
                n_pipe[ST_CORD0+i].cx = r_pipe[ST_CORD0+i-1].cx - v_dx;
                n_pipe[ST_CORD0+i].cy = r_pipe[ST_CORD0+i-1].cy + v_dy;
                n_pipe[ST_CORD0+i].cz = r_pipe[ST_CORD0+i-1].cz - v_at;
            end else begin
                n_pipe[ST_CORD0+i].cx = r_pipe[ST_CORD0+i-1].cx + v_dx;
                n_pipe[ST_CORD0+i].cy = r_pipe[ST_CORD0+i-1].cy - v_dy;
                n_pipe[ST_CORD0+i].cz = r_pipe[ST_CORD0+i-1].cz + v_at;
            end
        end

        n_pipe[ST_TRIG] = r_pipe[ST_TRIG-1];
        v_cx = r_pipe[ST_TRIG-1].flip ? -r_pipe[ST_TRIG-1].cx : r_pipe[ST_TRIG-1].cx;
        v_cy = r_pipe[ST_TRIG-1].flip ? -r_pipe[ST_TRIG-1].cy : r_pipe[ST_TRIG-1].cy;
        n_pipe[ST_TRIG].c = v_cx[WORD_BITS-1:0];
        n_pipe[ST_TRIG].s = v_cy[WORD_BITS-1:0];

        // Velocity and force into body axes.
        n_pipe[ST_P1] = r_pipe[ST_P1-1];
        n_pipe[ST_P1].mp[0] = mag_word(r_pipe[ST_P1-1].vx) * mag_word(r_pipe[ST_P1-1].c);
        n_pipe[ST_P1].mn[0] = r_pipe[ST_P1-1].vx[WORD_BITS-1] ^ r_pipe[ST_P1-1].c[WORD_BITS-1];
        n_pipe[ST_P1].mp[1] = mag_word(r_pipe[ST_P1-1].vy) * mag_word(r_pipe[ST_P1-1].s);
        n_pipe[ST_P1].mn[1] = r_pipe[ST_P1-1].vy[WORD_BITS-1] ^ r_pipe[ST_P1-1].s[WORD_BITS-1];
        n_pipe[ST_P1].mp[2] = mag_word(r_pipe[ST_P1-1].vx) * mag_word(r_pipe[ST_P1-1].s);
        n_pipe[ST_P1].mn[2] = r_pipe[ST_P1-1].vx[WORD_BITS-1] ^ ~r_pipe[ST_P1-1].s[WORD_BITS-1];
        n_pipe[ST_P1].mp[3] = mag_word(r_pipe[ST_P1-1].vy) * mag_word(r_pipe[ST_P1-1].c);
        n_pipe[ST_P1].mn[3] = r_pipe[ST_P1-1].vy[WORD_BITS-1] ^ r_pipe[ST_P1-1].c[WORD_BITS-1];
        n_pipe[ST_P1].mp[4] = mag_word(r_force) * mag_word(r_pipe[ST_P1-1].s);
        n_pipe[ST_P1].mn[4] = r_force[WORD_BITS-1] ^ r_pipe[ST_P1-1].s[WORD_BITS-1];
        n_pipe[ST_P1].mp[5] = mag_word(r_force) * mag_word(r_pipe[ST_P1-1].c);
        n_pipe[ST_P1].mn[5] = r_force[WORD_BITS-1] ^ r_pipe[ST_P1-1].c[WORD_BITS-1];

        n_pipe[ST_R1] = r_pipe[ST_R1-1];
        for (int j = 0; j < NUM_MULS; j++) begin
            v_res = mul_round(r_pipe[ST_R1-1].mn[j], r_pipe[ST_R1-1].mp[j], TRIG_FRAC);
            n_pipe[ST_R1].w[j] = v_res[WORD_BITS-1:0];
            n_pipe[ST_R1].clip = n_pipe[ST_R1].clip | v_res[WORD_BITS];
        end

        n_pipe[ST_B] = r_pipe[ST_B-1];
        v_res = sat_add(r_pipe[ST_B-1].w[0], r_pipe[ST_B-1].w[1]);
        n_pipe[ST_B].w[0] = v_res[WORD_BITS-1:0];
        n_pipe[ST_B].clip = n_pipe[ST_B].clip | v_res[WORD_BITS];
        v_res = sat_add(r_pipe[ST_B-1].w[2], r_pipe[ST_B-1].w[3]);
        n_pipe[ST_B].w[1] = v_res[WORD_BITS-1:0];
        n_pipe[ST_B].clip = n_pipe[ST_B].clip | v_res[WORD_BITS];
        n_pipe[ST_B].w[2] = r_pipe[ST_B-1].w[4];
        n_pipe[ST_B].w[3] = r_pipe[ST_B-1].w[5];

        // Momentum cross terms.
        n_pipe[ST_P2] = r_pipe[ST_P2-1];
        v_m1 = {1'b0, r_mass_one};
        v_m2 = {1'b0, r_mass_two};
        v_dm = sat_sub(v_m1, v_m2);
        n_pipe[ST_P2].clip  = r_pipe[ST_P2-1].clip | v_dm[WORD_BITS];
        n_pipe[ST_P2].mp[0] = mag_word(v_m2) * mag_word(r_pipe[ST_P2-1].w[1]);
        n_pipe[ST_P2].mn[0] = r_pipe[ST_P2-1].w[1][WORD_BITS-1];
        n_pipe[ST_P2].mp[1] = mag_word(v_m1) * mag_word(r_pipe[ST_P2-1].w[0]);
        n_pipe[ST_P2].mn[1] = r_pipe[ST_P2-1].w[0][WORD_BITS-1];
        n_pipe[ST_P2].mp[2] = mag_word(v_dm[WORD_BITS-1:0]) * mag_word(r_pipe[ST_P2-1].w[0]);
        n_pipe[ST_P2].mn[2] = v_dm[WORD_BITS-1] ^ r_pipe[ST_P2-1].w[0][WORD_BITS-1];

        n_pipe[ST_R2] = r_pipe[ST_R2-1];
        v_res = mul_round(r_pipe[ST_R2-1].mn[0], r_pipe[ST_R2-1].mp[0], FRAC_BITS);
        n_pipe[ST_R2].w[4] = v_res[WORD_BITS-1:0];
        n_pipe[ST_R2].clip = n_pipe[ST_R2].clip | v_res[WORD_BITS];
        v_res = mul_round(r_pipe[ST_R2-1].mn[1], r_pipe[ST_R2-1].mp[1], FRAC_BITS);
        n_pipe[ST_R2].w[5] = v_res[WORD_BITS-1:0];
        n_pipe[ST_R2].clip = n_pipe[ST_R2].clip | v_res[WORD_BITS];
        v_res = mul_round(r_pipe[ST_R2-1].mn[2], r_pipe[ST_R2-1].mp[2], FRAC_BITS);
        n_pipe[ST_R2].w[0] = v_res[WORD_BITS-1:0];
        n_pipe[ST_R2].clip = n_pipe[ST_R2].clip | v_res[WORD_BITS];

        n_pipe[ST_P3] = r_pipe[ST_P3-1];
        n_pipe[ST_P3].mp[0] = mag_word(r_pipe[ST_P3-1].w[4]) * mag_word(r_pipe[ST_P3-1].om);
        n_pipe[ST_P3].mn[0] = r_pipe[ST_P3-1].w[4][WORD_BITS-1] ^ r_pipe[ST_P3-1].om[WORD_BITS-1];
        n_pipe[ST_P3].mp[1] = mag_word(r_pipe[ST_P3-1].w[5]) * mag_word(r_pipe[ST_P3-1].om);
        n_pipe[ST_P3].mn[1] = r_pipe[ST_P3-1].w[5][WORD_BITS-1] ^ r_pipe[ST_P3-1].om[WORD_BITS-1];
        n_pipe[ST_P3].mp[2] = mag_word(r_pipe[ST_P3-1].w[0]) * mag_word(r_pipe[ST_P3-1].w[1]);
        n_pipe[ST_P3].mn[2] = r_pipe[ST_P3-1].w[0][WORD_BITS-1] ^ r_pipe[ST_P3-1].w[1][WORD_BITS-1];

        n_pipe[ST_R3] = r_pipe[ST_R3-1];
        v_res = mul_round(r_pipe[ST_R3-1].mn[0], r_pipe[ST_R3-1].mp[0], FRAC_BITS);
        n_pipe[ST_R3].w[0] = v_res[WORD_BITS-1:0];
        n_pipe[ST_R3].clip = n_pipe[ST_R3].clip | v_res[WORD_BITS];
        v_res = mul_round(r_pipe[ST_R3-1].mn[1], r_pipe[ST_R3-1].mp[1], FRAC_BITS);
        n_pipe[ST_R3].w[1] = v_res[WORD_BITS-1:0];
        n_pipe[ST_R3].clip = n_pipe[ST_R3].clip | v_res[WORD_BITS];
        v_res = mul_round(r_pipe[ST_R3-1].mn[2], r_pipe[ST_R3-1].mp[2], FRAC_BITS);
        n_pipe[ST_R3].w[4] = v_res[WORD_BITS-1:0];
        n_pipe[ST_R3].clip = n_pipe[ST_R3].clip | v_res[WORD_BITS];

        n_pipe[ST_NUM] = r_pipe[ST_NUM-1];
        v_res = sat_add(r_pipe[ST_NUM-1].w[0], r_pipe[ST_NUM-1].w[2]);
        n_pipe[ST_NUM].w[0] = v_res[WORD_BITS-1:0];
        n_pipe[ST_NUM].clip = n_pipe[ST_NUM].clip | v_res[WORD_BITS];
        v_res = sat_sub(r_pipe[ST_NUM-1].w[3], r_pipe[ST_NUM-1].w[1]);
        n_pipe[ST_NUM].w[1] = v_res[WORD_BITS-1:0];
        n_pipe[ST_NUM].clip = n_pipe[ST_NUM].clip | v_res[WORD_BITS];

        // Dividers: body-axis accelerations and the spin term.
        n_pipe[ST_DSET] = r_pipe[ST_DSET-1];
        for (int j = 0; j < NUM_DIVS; j++) begin
            v_num = (j == 2) ? r_pipe[ST_DSET-1].w[4] : r_pipe[ST_DSET-1].w[j];
            n_pipe[ST_DSET].dneg[j] = v_num[WORD_BITS-1];
            n_pipe[ST_DSET].dnz[j]  = (v_num == '0);
            n_pipe[ST_DSET].dn[j]   = {mag_word(v_num), {FRAC_BITS{1'b0}}};
            n_pipe[ST_DSET].rem[j]  = '0;
            n_pipe[ST_DSET].q[j]    = '0;
        end

        for (int k = 0; k < DIV_STEPS; k++) begin
            n_pipe[ST_DIV0+k] = r_pipe[ST_DIV0+k-1];
            for (int j = 0; j < NUM_DIVS; j++) begin
                v_rem2 = {r_pipe[ST_DIV0+k-1].rem[j][WORD_BITS-2:0],
                          r_pipe[ST_DIV0+k-1].dn[j][DIV_STEPS-1]};
                v_ge   = (v_rem2 >= w_den[j]);
                n_pipe[ST_DIV0+k].rem[j] = v_ge ? (v_rem2 - w_den[j]) : v_rem2;
                n_pipe[ST_DIV0+k].q[j]   = {r_pipe[ST_DIV0+k-1].q[j][DIV_STEPS-2:0], v_ge};
                n_pipe[ST_DIV0+k].dn[j]  = r_pipe[ST_DIV0+k-1].dn[j] << 1;
            end
        end

        n_pipe[ST_DFIN] = r_pipe[ST_DFIN-1];
        for (int j = 0; j < NUM_DIVS; j++) begin
            v_q = {1'b0, r_pipe[ST_DFIN-1].q[j]}
                + (DIV_STEPS+1)'({r_pipe[ST_DFIN-1].rem[j], 1'b0} >= {1'b0, w_den[j]});
            if (r_pipe[ST_DFIN-1].dnz[j]) begin
                v_res = '0;
            end else if (w_den[j] == '0) begin
                v_res = {1'b1, r_pipe[ST_DFIN-1].dneg[j] ? WORD_MIN : WORD_MAX};
            end else begin
                v_res = sat_mag(r_pipe[ST_DFIN-1].dneg[j], 64'(v_q));
            end
            n_pipe[ST_DFIN].w[(j == 2) ? 7 : j] = v_res[WORD_BITS-1:0];
            n_pipe[ST_DFIN].clip = n_pipe[ST_DFIN].clip | v_res[WORD_BITS];
        end

        // Back to world axes plus the frame terms.
        n_pipe[ST_P4] = r_pipe[ST_P4-1];
        n_pipe[ST_P4].mp[0] = mag_word(r_pipe[ST_P4-1].w[0]) * mag_word(r_pipe[ST_P4-1].c);
        n_pipe[ST_P4].mn[0] = r_pipe[ST_P4-1].w[0][WORD_BITS-1] ^ r_pipe[ST_P4-1].c[WORD_BITS-1];
        n_pipe[ST_P4].mp[1] = mag_word(r_pipe[ST_P4-1].w[1]) * mag_word(r_pipe[ST_P4-1].s);
        n_pipe[ST_P4].mn[1] = r_pipe[ST_P4-1].w[1][WORD_BITS-1] ^ r_pipe[ST_P4-1].s[WORD_BITS-1];
        n_pipe[ST_P4].mp[2] = mag_word(r_pipe[ST_P4-1].w[0]) * mag_word(r_pipe[ST_P4-1].s);
        n_pipe[ST_P4].mn[2] = r_pipe[ST_P4-1].w[0][WORD_BITS-1] ^ r_pipe[ST_P4-1].s[WORD_BITS-1];
        n_pipe[ST_P4].mp[3] = mag_word(r_pipe[ST_P4-1].w[1]) * mag_word(r_pipe[ST_P4-1].c);
        n_pipe[ST_P4].mn[3] = r_pipe[ST_P4-1].w[1][WORD_BITS-1] ^ r_pipe[ST_P4-1].c[WORD_BITS-1];
        n_pipe[ST_P4].mp[4] = mag_word(r_pipe[ST_P4-1].om) * mag_word(r_pipe[ST_P4-1].vy);
        n_pipe[ST_P4].mn[4] = r_pipe[ST_P4-1].om[WORD_BITS-1] ^ r_pipe[ST_P4-1].vy[WORD_BITS-1];
        n_pipe[ST_P4].mp[5] = mag_word(r_pipe[ST_P4-1].om) * mag_word(r_pipe[ST_P4-1].vx);
        n_pipe[ST_P4].mn[5] = r_pipe[ST_P4-1].om[WORD_BITS-1] ^ r_pipe[ST_P4-1].vx[WORD_BITS-1];

        n_pipe[ST_R4] = r_pipe[ST_R4-1];
        for (int j = 0; j < NUM_MULS; j++) begin
            v_res = mul_round(r_pipe[ST_R4-1].mn[j], r_pipe[ST_R4-1].mp[j],
                              (j < 4) ? TRIG_FRAC : FRAC_BITS);
            n_pipe[ST_R4].w[j] = v_res[WORD_BITS-1:0];
            n_pipe[ST_R4].clip = n_pipe[ST_R4].clip | v_res[WORD_BITS];
        end

        n_pipe[ST_S1] = r_pipe[ST_S1-1];
        v_res = sat_sub(r_pipe[ST_S1-1].w[0], r_pipe[ST_S1-1].w[1]);
        n_pipe[ST_S1].w[0] = v_res[WORD_BITS-1:0];
        n_pipe[ST_S1].clip = n_pipe[ST_S1].clip | v_res[WORD_BITS];
        v_res = sat_add(r_pipe[ST_S1-1].w[2], r_pipe[ST_S1-1].w[3]);
        n_pipe[ST_S1].w[1] = v_res[WORD_BITS-1:0];
        n_pipe[ST_S1].clip = n_pipe[ST_S1].clip | v_res[WORD_BITS];

        n_pipe[ST_OUT] = r_pipe[ST_OUT-1];
        v_res = sat_sub(r_pipe[ST_OUT-1].w[0], r_pipe[ST_OUT-1].w[4]);
        n_pipe[ST_OUT].w[0] = v_res[WORD_BITS-1:0];
        n_pipe[ST_OUT].clip = n_pipe[ST_OUT].clip | v_res[WORD_BITS];
        v_res = sat_add(r_pipe[ST_OUT-1].w[1], r_pipe[ST_OUT-1].w[5]);
        n_pipe[ST_OUT].w[1] = v_res[WORD_BITS-1:0];
        n_pipe[ST_OUT].clip = n_pipe[ST_OUT].clip | v_res[WORD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pipe <= n_pipe;
        end
    end

    assign m_axis_tvalid = r_vld[ST_OUT];
    assign m_axis_tdata  = {r_pipe[ST_OUT].w[7], r_pipe[ST_OUT].w[1], r_pipe[ST_OUT].w[0],
                            r_pipe[ST_OUT].om, r_pipe[ST_OUT].vy, r_pipe[ST_OUT].vx};
    assign m_axis_tuser  = r_pipe[ST_OUT].clip;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the rigid-ellipse fluid right-hand-side pipeline.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import refor_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 100;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    typedef logic [6:0][31:0] t_result;
    typedef struct {
        logic [31:0] angle, vel_x, vel_y, spin;
        bit          typed;
        t_result     want;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [WORD_BITS-1:0]     i_cfg_wdata;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [4*WORD_BITS-1:0]   s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [6*WORD_BITS-1:0]   m_axis_tdata;
    logic [0:0]               m_axis_tuser;

    rigid_ellipse_fluid_ode_rhs dut (.*);

    // Register copies used by the predictor.
    logic [30:0] mass_one, mass_two, inertia;
    logic [31:0] force_y;

    t_result accel_q[$];
    bit      clip_seen;
    int      mismatches, beats_in, beats_out, clipped_out, settings_run;
    int      cycles = 0;
    int      send_idle, recv_idle;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint from_mag(input bit neg, input logic [127:0] m);
        if (m > (neg ? 128'h80000000 : 128'h7FFFFFFF)) begin
            clip_seen = 1'b1;
            return neg ? WMIN : WMAX;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint q_mul(input longint a, input longint b, input int sh);
        logic [127:0] p;
        p = {64'b0, mag(a)} * {64'b0, mag(b)};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        return from_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint q_add(input longint a, input longint b);
        longint r;
        r = a + b;
        if (r > WMAX) begin clip_seen = 1'b1; return WMAX; end
        if (r < WMIN) begin clip_seen = 1'b1; return WMIN; end
        return r;
    endfunction

    function automatic longint q_sub(input longint a, input longint b);
        longint nb;
        nb = -b;
        if (b == WMIN) begin
            clip_seen = 1'b1;
            nb = WMAX;
        end
        return q_add(a, nb);
    endfunction

    function automatic longint q_div(input longint n, input longint d);
        logic [127:0] num, quo, rem, den;
        if (n == 0) return 0;
        if (d <= 0) begin
            clip_seen = 1'b1;
            return n < 0 ? WMIN : WMAX;
        end
        den = 128'(d);
        num = {64'b0, mag(n)} << FRAC_BITS;
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem) quo = quo + 1;
        return from_mag(n < 0, quo);
    endfunction

    function automatic void rotor(input longint ang, output longint c, output longint s);
        logic [31:0] turn_step [18] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F};
        logic [127:0] p;
        logic [31:0]  phase;
        bit           flip;
        longint       x, y, z, dx, dy;
        p = {64'b0, mag(ang)} * {64'b0, INV_TURN};
        p = (p + (128'd1 << (TURN_SHIFT - 1))) >> TURN_SHIFT;
        phase = p[31:0];
        if (ang < 0) phase = 32'd0 - phase;
        flip = ((phase + 32'h40000000) & 32'h80000000) != 0;
        if (flip) phase = phase ^ 32'h80000000;
        z = longint'($signed(phase));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(turn_step[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(turn_step[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_result body_rates(input logic [31:0] angle, vel_x, vel_y, spin);
        longint ang, vx, vy, om, m1, m2, m3, fy, c, s;
        longint bu, bw, g1, g2, du, dw, ax, ay, aw;
        t_result r;
        clip_seen = 1'b0;
        ang = longint'($signed(angle));
        vx  = longint'($signed(vel_x));
        vy  = longint'($signed(vel_y));
        om  = longint'($signed(spin));
        m1  = longint'(mass_one);
        m2  = longint'(mass_two);
        m3  = longint'(inertia);
        fy  = longint'($signed(force_y));
        rotor(ang, c, s);
        bu = q_add(q_mul(vx, c, TRIG_FRAC), q_mul(vy, s, TRIG_FRAC));
        bw = q_add(q_mul(vx, -s, TRIG_FRAC), q_mul(vy, c, TRIG_FRAC));
        g1 = q_mul(fy, s, TRIG_FRAC);
        g2 = q_mul(fy, c, TRIG_FRAC);
        du = q_div(q_add(q_mul(q_mul(m2, bw, FRAC_BITS), om, FRAC_BITS), g1), m1);
        dw = q_div(q_sub(g2, q_mul(q_mul(m1, bu, FRAC_BITS), om, FRAC_BITS)), m2);
        ax = q_sub(q_sub(q_mul(du, c, TRIG_FRAC), q_mul(dw, s, TRIG_FRAC)),
                   q_mul(om, vy, FRAC_BITS));
        ay = q_add(q_add(q_mul(du, s, TRIG_FRAC), q_mul(dw, c, TRIG_FRAC)),
                   q_mul(om, vx, FRAC_BITS));
        aw = q_div(q_mul(q_mul(q_sub(m1, m2), bu, FRAC_BITS), bw, FRAC_BITS), m3);
        r[0] = vel_x;
        r[1] = vel_y;
        r[2] = spin;
        r[3] = ax[31:0];
        r[4] = ay[31:0];
        r[5] = aw[31:0];
        r[6] = {31'b0, clip_seen};
        return r;
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_result want, got;
        string   names [7] = '{"rate_x", "rate_y", "rate_angle", "accel_x", "accel_y",
                               "accel_spin", "saturated"};
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            got = {{31'b0, m_axis_tuser}, m_axis_tdata};
            if (m_axis_tuser[0]) clipped_out++;
            if (accel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat %h", m_axis_tdata);
            end else begin
                want = accel_q.pop_front();
                for (int i = 0; i < 7; i++) begin
                    if (want[i] !== got[i]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d %s: expected %h got %h",
                                     beats_out, names[i], want[i], got[i]);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_MASS_ONE: mass_one = val[30:0];
            REG_MASS_TWO: mass_two = val[30:0];
            REG_INERTIA:  inertia  = val[30:0];
            REG_FORCE:    force_y  = val;
        endcase
    endtask

    task automatic wait_drained();
        while (accel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_beat(input t_row row);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {row.spin, row.vel_y, row.vel_x, row.angle};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        accel_q.push_back(row.typed ? row.want
                                    : body_rates(row.angle, row.vel_x, row.vel_y, row.spin));
        beats_in++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
            8: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($urandom_range(0, 6)) - 32'd3;
        endcase
    endfunction

    function automatic t_row plain(input logic [31:0] a, vx, vy, om);
        t_row r;
        r.angle = a; r.vel_x = vx; r.vel_y = vy; r.spin = om;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    initial begin
        t_row         lead [$];
        t_row         row;
        logic [31:0]  mass_set [6][4] = '{
            '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00000000},
            '{32'h00020000, 32'h00030000, 32'h00008000, 32'hFFF63A24},
            '{32'h00000001, 32'h00000001, 32'h00000001, 32'h7FFFFFFF},
            '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000},
            '{32'h00000000, 32'h00010000, 32'h00000000, 32'h00010000},
            '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000}};

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        clipped_out = 0;
        settings_run = 0;
        send_idle = 0;
        recv_idle = 0;
        mass_one = 31'h10000;
        mass_two = 31'h10000;
        inertia  = 31'h10000;
        force_y  = 32'h0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero velocity with zero force gives zero accelerations at any angle and spin.
        row = plain(32'h00000000, 32'h0, 32'h0, 32'h0);
        row.typed = 1'b1;
        lead.push_back(row);
        row = plain(32'h7FFFFFFF, 32'h0, 32'h0, 32'h80000000);
        row.typed = 1'b1;
        row.want[2] = 32'h80000000;
        lead.push_back(row);
        lead.push_back(plain(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        lead.push_back(plain(32'h0003243F, 32'h00010000, 32'h00020000, 32'h00010000));
        lead.push_back(plain(32'hFFFCDBC1, 32'h00010000, 32'hFFFF0000, 32'hFFFF0000));
        lead.push_back(plain(32'h00019220, 32'h00030000, 32'h00000000, 32'h00008000));
        lead.push_back(plain(32'hFFFE6DE0, 32'h80000000, 32'h80000000, 32'h80000000));
        lead.push_back(plain(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        lead.push_back(plain(32'h00000001, 32'hFFFFFFFF, 32'h00000001, 32'h00000001));
        lead.push_back(plain(32'h0000C910, 32'h00050000, 32'hFFFB0000, 32'h00100000));
        foreach (lead[i]) send_beat(lead[i]);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph % 3 == 0) ? 33 : (ph % 3 == 1) ? 85 : 0;
            recv_idle = (ph % 3 == 0) ? 85 : (ph % 3 == 1) ? 33 : 0;
            if (ph == 5) begin
                mass_set[5][0] = $urandom_range(1, 32'h00080000);
                mass_set[5][1] = $urandom_range(1, 32'h00080000);
                mass_set[5][2] = $urandom_range(1, 32'h00080000);
                mass_set[5][3] = pick_word();
            end
            if (ph > 0) begin
                write_reg(REG_MASS_ONE, mass_set[ph][0]);
                write_reg(REG_MASS_TWO, mass_set[ph][1]);
                write_reg(REG_INERTIA,  mass_set[ph][2]);
                write_reg(REG_FORCE,    mass_set[ph][3]);
            end
            settings_run++;
            for (int n = 0; n < 90; n++) begin
                row = plain($urandom_range(0, 1) ?
                            32'($urandom_range(0, 32'hE0000)) - 32'h70000 : pick_word(),
                            pick_word(), pick_word(), pick_word());
                send_beat(row);
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        $display("%0d beats sent, %0d checked, %0d register settings, %0d with clip flag",
                 beats_in, beats_out, settings_run, clipped_out);
        if (mismatches == 0 && accel_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, accel_q.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
